// ===== src/ssfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfs_pkg: shared types and constants of the status frame scanner
// Payload structs of both channels and the structs that pass between the
// top level and the motor cells.
// ----------------------------------------------------------------------------
package ssfs_pkg;

	localparam int FRAME_LEN = 8;
	localparam int IDX_W     = 3;
	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_response;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0] motor_index;
		logic [15:0]      position;
		logic             frame_ok;
		logic             all_ok;
		logic             last_result;
	} out_t;

	// Frame candidate seen by every motor cell in the cycle a byte is taken.
	typedef struct packed {
		logic        test;
		logic [7:0]  id;
		logic        chk_ok;
		logic [15:0] position;
	} probe_t;

	// One motor's reported status, held in the output chain.
	typedef struct packed {
		logic        ok;
		logic [15:0] position;
	} snap_t;

endpackage

// ===== src/ssfs_byte_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfs_byte_cell: one stage of the frame window
// Holds one byte and takes its neighbor's byte whenever a byte is kept, unless clear empties it.
// ----------------------------------------------------------------------------
module ssfs_byte_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

// ===== src/ssfs_motor_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfs_motor_cell: status slot of one motor
// Latches the first frame carrying this motor's id and, at the end of a
// reply, loads the status into an output chain that shifts toward cell 0.
// ----------------------------------------------------------------------------
module ssfs_motor_cell import ssfs_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  probe_t probe,
	input  logic   clear,
	input  logic   load,
	input  logic   shift,
	input  snap_t  snap_in,
	output snap_t  snap_out,
	output logic   ok_next
);

	localparam logic [7:0] BUS_ID = 8'(INDEX + 1);

	logic        matched_q;
	logic        good_q;
	logic [15:0] pos_q;
	logic        hit;
	logic        matched_n;
	logic        good_n;
	logic [15:0] pos_n;
	snap_t       snap_q;

	// Only the first frame for this id counts, even when its checksum fails.
	assign hit       = probe.test && (probe.id == BUS_ID) && !matched_q;
	assign matched_n = matched_q | hit;
	assign good_n    = hit ? probe.chk_ok : good_q;
	assign pos_n     = hit ? probe.position : pos_q;
	assign ok_next   = matched_n & good_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_q <= 1'b0;
			good_q    <= 1'b0;
			pos_q     <= '0;
		end else if (clear) begin
			matched_q <= 1'b0;
			good_q    <= 1'b0;
			pos_q     <= '0;
		end else begin
			matched_q <= matched_n;
			good_q    <= good_n;
			pos_q     <= pos_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			snap_q.ok       <= ok_next;
			snap_q.position <= ok_next ? pos_n : 16'd0;
		end else if (shift) begin
			snap_q <= snap_in;
		end
	end

	assign snap_out = snap_q;

endmodule

// ===== src/servo_status_frame_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_status_frame_scanner: sync-read reply scanner for a serial servo bus
// Finds each motor's first status frame in the reply and reports them.
// ----------------------------------------------------------------------------
// Usage: reply bytes enter on in_valid/in_ready/in_data, one transaction per
// byte, one byte per cycle. At most MOTORS*8 bytes are kept; later ones are
// dropped. A byte with end_of_response set closes the reply: MOTORS results,
// one per motor in index order, leave on out_valid/out_ready/out_data starting
// the cycle after that byte, one per cycle while out_ready is high. The last
// one carries last_result. The frame test runs on the window as the byte is
// taken, combinationally, on the bytes of an eight-stage byte cell chain.
// Results drain from a chain of motor cells; while they drain, ordinary bytes
// of the next reply are still taken, but a further end-of-response byte is
// held off (in_ready low) until the last result has been taken. A stalled
// receiver thus stalls only that closing byte. Reset clears the window, the
// byte count and all motor status, and drops any results not yet taken.
// ----------------------------------------------------------------------------
module servo_status_frame_scanner import ssfs_pkg::*; #(
	parameter int MOTORS = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int BUF_BYTES = MOTORS * FRAME_LEN;
	localparam int CNT_W     = $clog2(BUF_BYTES + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_n;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic             all_q;
	logic             in_acc;
	logic             out_acc;
	logic             take;
	logic             close;
	logic             is_last;
	logic [7:0]       win [FRAME_LEN];
	logic [7:0]       sum;
	probe_t           probe;
	snap_t            snap [MOTORS];
	logic [MOTORS-1:0] ok_next;

	assign in_ready = !busy_q || !in_data.end_of_response;
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign take     = in_acc && (count_q < CNT_W'(BUF_BYTES));
	assign close    = in_acc && in_data.end_of_response;
	assign count_n  = count_q + CNT_W'(take);
	assign is_last  = (idx_q == IDX_W'(MOTORS - 1));

	for (genvar i = 0; i < FRAME_LEN; i++) begin : g_win
		logic [7:0] d;
		if (i == FRAME_LEN - 1) begin : g_tail
			assign d = in_data.rx_byte;
		end else begin : g_body
			assign d = win[i+1];
		end
		ssfs_byte_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (take),
			.clear (close),
			.d     (d),
			.q     (win[i])
		);
	end

	// The window after this byte is cells 1..7 followed by the new byte.
	assign sum = win[3] + win[4] + win[5] + win[6] + win[7];
	always_comb begin
		probe.test     = take && (count_q >= CNT_W'(FRAME_LEN - 1))
			&& (win[1] == SYNC_BYTE) && (win[2] == SYNC_BYTE);
		probe.id       = win[3];
		probe.chk_ok   = (~sum == in_data.rx_byte);
		probe.position = {win[7], win[6]};
	end

	for (genvar m = 0; m < MOTORS; m++) begin : g_motor
		snap_t s_in;
		if (m == MOTORS - 1) begin : g_end
			assign s_in = '0;
		end else begin : g_mid
			assign s_in = snap[m+1];
		end
		ssfs_motor_cell #(.INDEX(m)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.probe   (probe),
			.clear   (close),
			.load    (close),
			.shift   (out_acc),
			.snap_in (s_in),
			.snap_out(snap[m]),
			.ok_next (ok_next[m])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			idx_q   <= '0;
			all_q   <= 1'b0;
		end else begin
			count_q <= close ? '0 : count_n;
			if (close) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				all_q  <= (count_n == CNT_W'(BUF_BYTES)) && (&ok_next);
			end else if (out_acc) begin
				if (is_last) begin
					busy_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign out_valid = busy_q;
	always_comb begin
		out_data.motor_index = idx_q;
		out_data.position    = snap[0].position;
		out_data.frame_ok    = snap[0].ok;
		out_data.all_ok      = all_q;
		out_data.last_result = is_last;
	end

endmodule

// ===== src/ssfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfs_checker: port-level checks of the status frame scanner
// Watches the result channel for ordering and consistency of each reply.
// ----------------------------------------------------------------------------
module ssfs_checker import ssfs_pkg::*; #(
	parameter int MOTORS = 6
) (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_result == (out_data.motor_index == IDX_W'(MOTORS - 1))))
		else $error("last_result does not match the final motor");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_result
		|=> out_valid && (out_data.motor_index == $past(out_data.motor_index) + 1'b1))
		else $error("results skipped or repeated a motor");

	a_reply_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_result |=> !out_valid)
		else $error("results continued past the final motor");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.frame_ok |-> (out_data.position == 16'd0))
		else $error("position reported for a motor without a good frame");

endmodule

bind servo_status_frame_scanner ssfs_checker #(.MOTORS(MOTORS)) u_ssfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for servo_status_frame_scanner
// Feeds reply bytes through the input handshake and predicts each reply's
// per-motor status. A short table of directed replies comes first. Then
// random replies follow, mostly well formed with random positions, bad
// checksums, dropped or repeated frames and noise. Both sides idle at random.
// Each result transaction is checked field by field against the predicted
// status, or against a status typed in by hand for the simplest replies.
// ----------------------------------------------------------------------------
module tb;
	import ssfs_pkg::*;

	localparam int MOTORS       = 6;
	localparam int KEEP_BYTES   = MOTORS * FRAME_LEN;
	localparam int IDLE_PCT     = 30;
	localparam int RANDOM_BYTES = 260;
	localparam int PLAN_ROWS    = 29;

	typedef enum logic [1:0] {ROW_FRAME, ROW_RAW, ROW_CLOSE} row_kind_t;

	// Status typed in by hand for a reply; it replaces the predicted one.
	typedef struct packed {
		logic              valid;
		logic [MOTORS-1:0] ok_mask;
		logic              all_ok;
		logic [15:0]       pos;
	} hand_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  id;
		logic [15:0] value;
		logic        bad;
		logic        close;
		hand_t       hand;
	} row_t;

	localparam hand_t NO_HAND = '0;

	localparam row_t PLAN [PLAN_ROWS] = '{
		'{ROW_CLOSE, 8'd0, 16'h0000, 1'b0, 1'b0, '{1'b1, 6'h00, 1'b0, 16'h0000}},
		'{ROW_FRAME, 8'd1, 16'hFFFE, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd2, 16'hFFFE, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd3, 16'hFFFE, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd4, 16'hFFFE, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd5, 16'hFFFE, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd6, 16'hFFFE, 1'b0, 1'b1, '{1'b1, 6'h3F, 1'b1, 16'hFFFE}},
		'{ROW_FRAME, 8'd1, 16'h0000, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd2, 16'h0000, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd3, 16'h0000, 1'b1, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd4, 16'h0000, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd5, 16'h0000, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd6, 16'h0000, 1'b0, 1'b1, '{1'b1, 6'h3B, 1'b0, 16'h0000}},
		'{ROW_FRAME, 8'd7, 16'h1234, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd0, 16'h5678, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd2, 16'h1111, 1'b1, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd2, 16'h2222, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd5, 16'h8001, 1'b0, 1'b0, NO_HAND},
		'{ROW_RAW,   8'd0, 16'h00FF, 1'b0, 1'b0, NO_HAND},
		'{ROW_RAW,   8'd0, 16'h00FF, 1'b0, 1'b0, NO_HAND},
		'{ROW_CLOSE, 8'd0, 16'h00A5, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd6, 16'h0102, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd5, 16'h7FFE, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd4, 16'h8000, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd3, 16'h00FF, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd2, 16'hFF00, 1'b0, 1'b0, NO_HAND},
		'{ROW_FRAME, 8'd1, 16'hA55A, 1'b0, 1'b0, NO_HAND},
		'{ROW_RAW,   8'd0, 16'h00FF, 1'b0, 1'b0, NO_HAND},
		'{ROW_CLOSE, 8'd0, 16'h0000, 1'b0, 1'b0, NO_HAND}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	// Predicted scanner state.
	logic [7:0]  recent [FRAME_LEN];
	int          kept;
	logic        seen [MOTORS];
	logic        sum_good [MOTORS];
	logic [15:0] seen_pos [MOTORS];

	out_t status_q [$];
	out_t status_want;
	int   errors;
	int   sent;
	bit   calm;

	servo_status_frame_scanner #(
		.MOTORS(MOTORS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("servo_status_frame_scanner test failed");
		$finish;
	end

	task automatic clear_scan();
		for (int k = 0; k < FRAME_LEN; k++) recent[k] = '0;
		kept = 0;
		for (int m = 0; m < MOTORS; m++) begin
			seen[m] = 1'b0;
			sum_good[m] = 1'b0;
			seen_pos[m] = '0;
		end
	endtask

	// Advances the predicted state by one accepted byte and, on the closing
	// byte, queues one status per motor.
	task automatic take_reply_byte(input in_t d, input hand_t hand);
		logic [7:0] sum;
		logic       ok;
		logic       all;
		out_t       r;
		int         m;
		if (kept < KEEP_BYTES) begin
			for (int k = 0; k < FRAME_LEN - 1; k++) recent[k] = recent[k + 1];
			recent[FRAME_LEN - 1] = d.rx_byte;
			kept++;
			if (kept >= FRAME_LEN && recent[0] == SYNC_BYTE && recent[1] == SYNC_BYTE
					&& recent[2] >= 1 && recent[2] <= MOTORS) begin
				m = recent[2] - 1;
				// Only a motor's first frame counts, good checksum or not.
				if (!seen[m]) begin
					seen[m] = 1'b1;
					sum = recent[2] + recent[3] + recent[4] + recent[5] + recent[6];
					sum = ~sum;
					sum_good[m] = (sum == recent[7]);
					seen_pos[m] = {recent[6], recent[5]};
				end
			end
		end
		if (d.end_of_response) begin
			all = (kept == KEEP_BYTES);
			for (int k = 0; k < MOTORS; k++)
				if (!(seen[k] && sum_good[k])) all = 1'b0;
			if (hand.valid) all = hand.all_ok;
			for (int k = 0; k < MOTORS; k++) begin
				ok = hand.valid ? hand.ok_mask[k] : (seen[k] && sum_good[k]);
				r.motor_index = IDX_W'(k);
				r.position = !ok ? 16'h0000 : (hand.valid ? hand.pos : seen_pos[k]);
				r.frame_ok = ok;
				r.all_ok = all;
				r.last_result = (k == MOTORS - 1);
				status_q.push_back(r);
			end
			clear_scan();
		end
	endtask

	// Called and left at a falling edge; one byte is one input transaction.
	task automatic push_byte(input in_t d, input hand_t hand);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do @(posedge clk); while (!in_ready);
		take_reply_byte(d, hand);
		sent++;
		@(negedge clk);
	endtask

	task automatic push_raw(input logic [7:0] b, input logic eor, input hand_t hand);
		in_t d;
		d.rx_byte = b;
		d.end_of_response = eor;
		push_byte(d, hand);
	endtask

	task automatic send_frame(input logic [7:0] id, input logic [15:0] pos, input logic bad,
			input logic close, input hand_t hand);
		logic [7:0] body [FRAME_LEN];
		logic [7:0] chk;
		body[0] = SYNC_BYTE;
		body[1] = SYNC_BYTE;
		body[2] = id;
		body[3] = 8'($urandom);
		body[4] = 8'($urandom);
		body[5] = pos[7:0];
		body[6] = pos[15:8];
		chk = body[2] + body[3] + body[4] + body[5] + body[6];
		chk = ~chk;
		if (bad) chk = chk ^ 8'($urandom_range(1, 255));
		body[7] = chk;
		for (int k = 0; k < FRAME_LEN - 1; k++) push_raw(body[k], 1'b0, NO_HAND);
		push_raw(body[FRAME_LEN - 1], close, hand);
	endtask

	// Holds the sender off until every queued status has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (status_q.size() != 0);
	endtask

	task automatic random_reply();
		int   style;
		int   n;
		int   tmp;
		int   j;
		int   drop;
		int   last;
		bit   closed;
		bit   close_extra;
		int   order [MOTORS];
		style = $urandom_range(0, 9);
		closed = 1'b0;
		if (style < 6) begin
			for (int k = 0; k < MOTORS; k++) order[k] = k;
			for (int k = MOTORS - 1; k > 0; k--) begin
				j = $urandom_range(0, k);
				tmp = order[k];
				order[k] = order[j];
				order[j] = tmp;
			end
			// Leading noise shifts the frames so that the last one can get cut off.
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			for (int k = 0; k < n; k++) push_raw(8'($urandom), 1'b0, NO_HAND);
			drop = ($urandom_range(0, 5) == 0) ? $urandom_range(0, MOTORS - 1) : -1;
			last = (drop == MOTORS - 1) ? MOTORS - 2 : MOTORS - 1;
			close_extra = ($urandom_range(0, 2) == 0);
			for (int k = 0; k < MOTORS; k++) begin
				if (k != drop) begin
					send_frame(8'(order[k] + 1), 16'($urandom), $urandom_range(0, 7) == 0,
						!close_extra && k == last, NO_HAND);
					if (!close_extra && k == last) closed = 1'b1;
					if (k != last && $urandom_range(0, 7) == 0)
						send_frame(8'(order[k] + 1), 16'($urandom), 1'($urandom_range(0, 1)),
							1'b0, NO_HAND);
				end
			end
		end else if (style < 8) begin
			n = $urandom_range(0, 3);
			for (int k = 0; k < n; k++)
				send_frame(8'($urandom_range(0, 7)), 16'($urandom),
					$urandom_range(0, 3) == 0, 1'b0, NO_HAND);
		end else begin
			n = $urandom_range(1, 60);
			for (int k = 0; k < n; k++)
				push_raw(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom), 1'b0, NO_HAND);
		end
		if (!closed) push_raw(8'($urandom), 1'b1, NO_HAND);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, got %h",
					$time, out_data);
				errors++;
			end else begin
				status_want = status_q.pop_front();
				check_field("motor_index", int'(status_want.motor_index),
					int'(out_data.motor_index));
				check_field("position", int'(status_want.position), int'(out_data.position));
				check_field("frame_ok", int'(status_want.frame_ok), int'(out_data.frame_ok));
				check_field("all_ok", int'(status_want.all_ok), int'(out_data.all_ok));
				check_field("last_result", int'(status_want.last_result),
					int'(out_data.last_result));
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		int start;
		int reply_no;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		errors = 0;
		sent = 0;
		calm = 1'b0;
		clear_scan();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			case (PLAN[i].kind)
				ROW_FRAME: begin
					send_frame(PLAN[i].id, PLAN[i].value, PLAN[i].bad, PLAN[i].close,
						PLAN[i].hand);
				end
				ROW_RAW: begin
					push_raw(PLAN[i].value[7:0], 1'b0, NO_HAND);
				end
				default: begin
					push_raw(PLAN[i].value[7:0], 1'b1, PLAN[i].hand);
				end
			endcase
		end
		drain_results();

		start = sent;
		reply_no = 0;
		while (sent < start + RANDOM_BYTES) begin
			calm = (reply_no == 2 || reply_no == 3);
			random_reply();
			if ($urandom_range(0, 3) == 0) drain_results();
			reply_no++;
		end
		calm = 1'b0;
		drain_results();
		repeat (20) @(negedge clk);

		if (errors == 0) begin
			$display("servo_status_frame_scanner test passed");
		end else begin
			$display("servo_status_frame_scanner test failed");
		end
		$finish;
	end

endmodule

// ===== servo_status_frame_scanner.f =====
src/ssfs_pkg.sv
src/ssfs_byte_cell.sv
src/ssfs_motor_cell.sv
src/servo_status_frame_scanner.sv
src/ssfs_checker.sv
tb/tb.sv
